[design/dau_pkg.sv]
// ----------------------------------------------------------------------------
// dau_pkg: shared types and constants for the duration arithmetic unit
// Operation codes, time constants and the flag structs that travel between
// the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package dau_pkg;

    localparam int DAY_BITS_DEF = 16;

    localparam int DAY_W  = 16;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;
    localparam int FAC_W  = 16;
    localparam int ACT_W  = 2;

    localparam int SEC_PER_MIN  = 60;
    localparam int MIN_PER_HOUR = 60;
    localparam int HOUR_PER_DAY = 24;
    localparam int SEC_PER_HOUR = 3600;
    localparam int SEC_PER_DAY  = 86400;

    // remainder widths of the constant dividers
    localparam int DAY_REM_W  = 17;
    localparam int HOUR_REM_W = 12;

    // power-of-two part of each constant divisor
    localparam int DAY_SHIFT  = 7;
    localparam int HOUR_SHIFT = 4;
    localparam int MIN_SHIFT  = 2;

    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [ACT_W-1:0] {
        ACT_ADD = 2'd0,
        ACT_SUB = 2'd1,
        ACT_MUL = 2'd2,
        ACT_DIV = 2'd3
    } action_t;

    typedef struct packed {
        logic bad;
        logic gt;
        logic lt;
        logic eq;
    } cmp_t;

    typedef struct packed {
        logic neg;
        logic ovf;
        logic dbz;
        logic bad;
        logic gt;
        logic lt;
        logic eq;
    } flag_t;

    localparam int CMP_W  = $bits(cmp_t);
    localparam int FLAG_W = $bits(flag_t);

endpackage

[design/duration_arithmetic_unit.sv]
// ----------------------------------------------------------------------------
// duration_arithmetic_unit: day/hour/minute/second duration ALU
// Add, subtract, scale or divide durations, with compare and status flags.
//
//   channel | handshake            | word
//   --------+----------------------+---------------------------------------
//   in      | in_valid / in_stall  | action, A and B durations, factor
//   out     | out_valid / out_stall| result duration, status, compare flags
//
// One word per cycle sustained while out_stall is low; the bit-per-stage factor
// divider makes up most of the pipeline depth.
// Reset clears only valid and pointer state; no clearing pass.
// out_stall freezes the back pipeline; the queue keeps taking words until
// full, then in_stall rises.
// ----------------------------------------------------------------------------
module duration_arithmetic_unit #(
    parameter int DAY_BITS = dau_pkg::DAY_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [dau_pkg::ACT_W-1:0]   action,
    input  logic [dau_pkg::DAY_W-1:0]   day_a,
    input  logic [dau_pkg::HOUR_W-1:0]  hour_a,
    input  logic [dau_pkg::MIN_W-1:0]   minute_a,
    input  logic [dau_pkg::SEC_W-1:0]   second_a,
    input  logic [dau_pkg::DAY_W-1:0]   day_b,
    input  logic [dau_pkg::HOUR_W-1:0]  hour_b,
    input  logic [dau_pkg::MIN_W-1:0]   minute_b,
    input  logic [dau_pkg::SEC_W-1:0]   second_b,
    input  logic [dau_pkg::FAC_W-1:0]   factor,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [dau_pkg::DAY_W-1:0]   res_day,
    output logic [dau_pkg::HOUR_W-1:0]  res_hour,
    output logic [dau_pkg::MIN_W-1:0]   res_minute,
    output logic [dau_pkg::SEC_W-1:0]   res_second,
    output logic                        negative,
    output logic                        overflow,
    output logic                        divide_by_zero,
    output logic                        bad_operand,
    output logic                        a_greater,
    output logic                        a_less,
    output logic                        a_equal
);
    import dau_pkg::*;

    localparam int TOT_W = DAY_BITS + 17;
    localparam int QW    = ACT_W + 2 * TOT_W + FAC_W + CMP_W;

    logic             fq_valid, fq_full, fq_empty, fq_pop, fq_push;
    action_t          f_act;
    logic [ACT_W-1:0] b_act;
    logic [TOT_W-1:0] f_ta, f_tb, b_ta, b_tb;
    logic [FAC_W-1:0] f_fac, b_fac;
    cmp_t             f_cmp, b_cmp;
    logic [QW-1:0]    q_din, q_dout;

    dau_front #(.DAY_BITS(DAY_BITS), .TOT_W(TOT_W)) u_front (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .action(action),
        .day_a(day_a), .hour_a(hour_a), .minute_a(minute_a), .second_a(second_a),
        .day_b(day_b), .hour_b(hour_b), .minute_b(minute_b), .second_b(second_b),
        .factor(factor),
        .q_valid(fq_valid), .q_full(fq_full),
        .q_act(f_act), .q_ta(f_ta), .q_tb(f_tb), .q_fac(f_fac), .q_cmp(f_cmp)
    );

    assign fq_push = fq_valid && !fq_full;
    assign q_din   = {f_act, f_ta, f_tb, f_fac, f_cmp};
    assign {b_act, b_ta, b_tb, b_fac, b_cmp} = q_dout;

    dau_fifo #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
        .clk(clk), .rst_n(rst_n),
        .push(fq_push), .din(q_din), .full(fq_full),
        .pop(fq_pop), .dout(q_dout), .empty(fq_empty)
    );

    dau_back #(.DAY_BITS(DAY_BITS), .TOT_W(TOT_W)) u_back (
        .clk(clk), .rst_n(rst_n),
        .q_empty(fq_empty), .q_pop(fq_pop),
        .q_act(action_t'(b_act)), .q_ta(b_ta), .q_tb(b_tb), .q_fac(b_fac), .q_cmp(b_cmp),
        .out_valid(out_valid), .out_stall(out_stall),
        .res_day(res_day), .res_hour(res_hour), .res_minute(res_minute),
        .res_second(res_second),
        .negative(negative), .overflow(overflow), .divide_by_zero(divide_by_zero),
        .bad_operand(bad_operand),
        .a_greater(a_greater), .a_less(a_less), .a_equal(a_equal)
    );

endmodule

[design/dau_fifo.sv]
// ----------------------------------------------------------------------------
// dau_fifo: small queue between front end and back end
// Register based, combinational read of the head word.
// ----------------------------------------------------------------------------
module dau_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty
);
    localparam int AW = $clog2(DEPTH);

    logic [W-1:0]  mem_reg [DEPTH];
    logic [AW-1:0] wr_reg, wr_next;
    logic [AW-1:0] rd_reg, rd_next;
    logic [AW:0]   cnt_reg, cnt_next;

    assign full  = (cnt_reg == (AW+1)'(DEPTH));
    assign empty = (cnt_reg == '0);
    assign dout  = mem_reg[rd_reg];

    always_comb
    begin
        wr_next  = push ? AW'(wr_reg + 1'b1) : wr_reg;
        rd_next  = pop  ? AW'(rd_reg + 1'b1) : rd_reg;
        cnt_next = cnt_reg + (AW+1)'(push) - (AW+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_reg] <= din;
        end
    end

endmodule

[design/dau_div.sv]
// ----------------------------------------------------------------------------
// dau_div: pipelined dividers
// dau_div: restoring divider, one quotient bit per stage, Q stages; side word
// travels with each item. Quotient must fit in Q bits.
// dau_cdiv: divide by a constant through reciprocal multiplication, two
// stages; side word travels with each item.
// ----------------------------------------------------------------------------
module dau_div #(
    parameter int N = 8,
    parameter int D = 8,
    parameter int Q = 8,
    parameter int P = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [N-1:0] num,
    input  logic [D-1:0] den,
    input  logic [P-1:0] side_in,
    output logic         out_valid,
    output logic [Q-1:0] quo,
    output logic [N-1:0] rem,
    output logic [P-1:0] side_out
);
    localparam int W = N + D + Q;

    logic         v_reg [Q];
    logic [N-1:0] r_reg [Q];
    logic [Q-1:0] q_reg [Q];
    logic [D-1:0] d_reg [Q];
    logic [P-1:0] s_reg [Q];

    for (genvar i = 0; i < Q; i++)
    begin : g_stage
        localparam int K = Q - 1 - i;

        logic         pv;
        logic [N-1:0] pr;
        logic [Q-1:0] pq;
        logic [D-1:0] pd;
        logic [P-1:0] ps;
        logic [W-1:0] dsh;
        logic [W-1:0] diff;
        logic         ge;
        logic [N-1:0] r_next;
        logic [Q-1:0] q_next;

        if (i == 0)
        begin : g_first
            assign pv = in_valid;
            assign pr = num;
            assign pq = '0;
            assign pd = den;
            assign ps = side_in;
        end
        else
        begin : g_rest
            assign pv = v_reg[i-1];
            assign pr = r_reg[i-1];
            assign pq = q_reg[i-1];
            assign pd = d_reg[i-1];
            assign ps = s_reg[i-1];
        end

        assign dsh  = W'(pd) << K;
        assign diff = W'(pr) - dsh;
        assign ge   = (W'(pr) >= dsh);

        always_comb
        begin
            r_next    = ge ? diff[N-1:0] : pr;
            q_next    = pq;
            q_next[K] = ge;
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                v_reg[i] <= 1'b0;
            end
            else if (en)
            begin
                v_reg[i] <= pv;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[i] <= r_next;
                q_reg[i] <= q_next;
                d_reg[i] <= pd;
                s_reg[i] <= ps;
            end
        end
    end

    assign out_valid = v_reg[Q-1];
    assign quo       = q_reg[Q-1];
    assign rem       = r_reg[Q-1];
    assign side_out  = s_reg[Q-1];

endmodule

module dau_cdiv #(
    parameter int N   = 12,
    parameter int DIV = 60,
    parameter int SH  = 0,
    parameter int Q   = 8,
    parameter int R   = 8,
    parameter int P   = 1
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic         in_valid,
    input  logic [N-1:0] num,
    input  logic [P-1:0] side_in,
    output logic         out_valid,
    output logic [Q-1:0] quo,
    output logic [R-1:0] rem,
    output logic [P-1:0] side_out
);
    // floor((num >> SH) * MUL / 2^(NS+L)) is exact for every NS-bit value
    localparam int ODD = DIV >> SH;
    localparam int NS  = N - SH;
    localparam int L   = $clog2(ODD);
    localparam int MW  = NS + 1;
    localparam int PW  = NS + MW;
    localparam int QF  = MW - L;
    localparam longint unsigned MUL =
        ((64'd1 << (NS + L)) + 64'(ODD) - 64'd1) / 64'(ODD);

    logic          v1_reg;
    logic [N-1:0]  n1_reg;
    logic [PW-1:0] p1_reg;
    logic [P-1:0]  s1_reg;
    logic          v2_reg;
    logic [Q-1:0]  q2_reg;
    logic [R-1:0]  r2_reg;
    logic [P-1:0]  s2_reg;
    logic [QF-1:0] qf;
    logic [N:0]    rem_full;

    always_comb
    begin
        qf       = p1_reg[PW-1:NS+L];
        rem_full = (N+1)'(n1_reg) - (N+1)'(qf) * (N+1)'(DIV);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg <= num;
            p1_reg <= PW'(num[N-1:SH]) * PW'(MUL);
            s1_reg <= side_in;
            q2_reg <= Q'(qf);
            r2_reg <= R'(rem_full);
            s2_reg <= s1_reg;
        end
    end

    assign out_valid = v2_reg;
    assign quo       = q2_reg;
    assign rem       = r2_reg;
    assign side_out  = s2_reg;

endmodule

[design/dau_front.sv]
// ----------------------------------------------------------------------------
// dau_front: input stage
// Takes a word, checks field ranges, compares A with B and converts both
// operands to total seconds.
// ----------------------------------------------------------------------------
module dau_front #(
    parameter int DAY_BITS = dau_pkg::DAY_BITS_DEF,
    parameter int TOT_W    = DAY_BITS + 17
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [dau_pkg::ACT_W-1:0]   action,
    input  logic [dau_pkg::DAY_W-1:0]   day_a,
    input  logic [dau_pkg::HOUR_W-1:0]  hour_a,
    input  logic [dau_pkg::MIN_W-1:0]   minute_a,
    input  logic [dau_pkg::SEC_W-1:0]   second_a,
    input  logic [dau_pkg::DAY_W-1:0]   day_b,
    input  logic [dau_pkg::HOUR_W-1:0]  hour_b,
    input  logic [dau_pkg::MIN_W-1:0]   minute_b,
    input  logic [dau_pkg::SEC_W-1:0]   second_b,
    input  logic [dau_pkg::FAC_W-1:0]   factor,
    output logic                        q_valid,
    input  logic                        q_full,
    output dau_pkg::action_t            q_act,
    output logic [TOT_W-1:0]            q_ta,
    output logic [TOT_W-1:0]            q_tb,
    output logic [dau_pkg::FAC_W-1:0]   q_fac,
    output dau_pkg::cmp_t               q_cmp
);
    import dau_pkg::*;

    localparam logic [DAY_W-1:0] DAY_MASK =
        (DAY_BITS >= DAY_W) ? {DAY_W{1'b1}} : DAY_W'((64'd1 << DAY_BITS) - 64'd1);
    localparam int KEY_W = DAY_W + HOUR_W + MIN_W + SEC_W;

    logic               valid_reg, valid_next;
    action_t            act_reg;
    logic [TOT_W-1:0]   ta_reg, tb_reg;
    logic [FAC_W-1:0]   fac_reg;
    cmp_t               cmp_reg;

    logic [DAY_W-1:0]   da, db;
    logic [KEY_W-1:0]   ka, kb;
    logic [TOT_W-1:0]   ta, tb;
    logic               bad_a, bad_b, take;
    cmp_t               cmp;

    assign in_stall = valid_reg && q_full;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        da    = day_a & DAY_MASK;
        db    = day_b & DAY_MASK;
        ka    = {da, hour_a, minute_a, second_a};
        kb    = {db, hour_b, minute_b, second_b};
        bad_a = (hour_a >= HOUR_W'(HOUR_PER_DAY)) || (minute_a >= MIN_W'(MIN_PER_HOUR))
                || (second_a >= SEC_W'(SEC_PER_MIN));
        bad_b = (hour_b >= HOUR_W'(HOUR_PER_DAY)) || (minute_b >= MIN_W'(MIN_PER_HOUR))
                || (second_b >= SEC_W'(SEC_PER_MIN));
        ta    = TOT_W'(da) * TOT_W'(SEC_PER_DAY) + TOT_W'(hour_a) * TOT_W'(SEC_PER_HOUR)
                + TOT_W'(minute_a) * TOT_W'(SEC_PER_MIN) + TOT_W'(second_a);
        tb    = TOT_W'(db) * TOT_W'(SEC_PER_DAY) + TOT_W'(hour_b) * TOT_W'(SEC_PER_HOUR)
                + TOT_W'(minute_b) * TOT_W'(SEC_PER_MIN) + TOT_W'(second_b);
        cmp.bad = bad_a || bad_b;
        cmp.gt  = (ka > kb);
        cmp.lt  = (ka < kb);
        cmp.eq  = (ka == kb);
        valid_next = take || (valid_reg && q_full);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            act_reg <= action_t'(action);
            ta_reg  <= ta;
            tb_reg  <= tb;
            fac_reg <= factor;
            cmp_reg <= cmp;
        end
    end

    assign q_valid = valid_reg;
    assign q_act   = act_reg;
    assign q_ta    = ta_reg;
    assign q_tb    = tb_reg;
    assign q_fac   = fac_reg;
    assign q_cmp   = cmp_reg;

endmodule

[design/dau_back.sv]
// ----------------------------------------------------------------------------
// dau_back: execution pipeline
// Operation stage, factor divider, then constant dividers that split total
// seconds into days, hours, minutes and seconds; output register last.
// ----------------------------------------------------------------------------
module dau_back #(
    parameter int DAY_BITS = dau_pkg::DAY_BITS_DEF,
    parameter int TOT_W    = DAY_BITS + 17
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_empty,
    output logic                        q_pop,
    input  dau_pkg::action_t            q_act,
    input  logic [TOT_W-1:0]            q_ta,
    input  logic [TOT_W-1:0]            q_tb,
    input  logic [dau_pkg::FAC_W-1:0]   q_fac,
    input  dau_pkg::cmp_t               q_cmp,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [dau_pkg::DAY_W-1:0]   res_day,
    output logic [dau_pkg::HOUR_W-1:0]  res_hour,
    output logic [dau_pkg::MIN_W-1:0]   res_minute,
    output logic [dau_pkg::SEC_W-1:0]   res_second,
    output logic                        negative,
    output logic                        overflow,
    output logic                        divide_by_zero,
    output logic                        bad_operand,
    output logic                        a_greater,
    output logic                        a_less,
    output logic                        a_equal
);
    import dau_pkg::*;

    localparam int PROD_W = TOT_W + FAC_W;
    localparam longint unsigned SEC_LIMIT =
        (64'd1 << DAY_BITS) * 64'(SEC_PER_DAY) - 64'd1;
    localparam logic [DAY_W-1:0] DAY_SAT =
        (DAY_BITS >= DAY_W) ? {DAY_W{1'b1}} : DAY_W'((64'd1 << DAY_BITS) - 64'd1);
    localparam int HS_W = FLAG_W + DAY_BITS;
    localparam int MS_W = HS_W + HOUR_W;

    logic adv;

    // operation stage
    logic [TOT_W:0]      sum;
    logic [PROD_W-1:0]   prod;
    logic [TOT_W-1:0]    r_next;
    logic [FAC_W-1:0]    den_next;
    flag_t               flag_next;
    logic                op_v_reg;
    logic [TOT_W-1:0]    op_r_reg;
    logic [FAC_W-1:0]    op_den_reg;
    flag_t               op_flag_reg;

    assign adv   = !out_valid || !out_stall;
    assign q_pop = adv && !q_empty;

    always_comb
    begin
        sum       = (TOT_W+1)'(q_ta) + (TOT_W+1)'(q_tb);
        prod      = PROD_W'(q_ta) * PROD_W'(q_fac);
        r_next    = '0;
        den_next  = FAC_W'(1);
        flag_next = '0;
        flag_next.bad = q_cmp.bad;
        flag_next.gt  = q_cmp.gt;
        flag_next.lt  = q_cmp.lt;
        flag_next.eq  = q_cmp.eq;
        if (!q_cmp.bad)
        begin
            unique case (q_act)
                ACT_ADD:
                begin
                    r_next        = sum[TOT_W-1:0];
                    flag_next.ovf = (sum > (TOT_W+1)'(SEC_LIMIT));
                end
                ACT_SUB:
                begin
                    if (q_ta >= q_tb)
                    begin
                        r_next = q_ta - q_tb;
                    end
                    else
                    begin
                        r_next        = q_tb - q_ta;
                        flag_next.neg = 1'b1;
                    end
                end
                ACT_MUL:
                begin
                    r_next        = prod[TOT_W-1:0];
                    flag_next.ovf = (prod > PROD_W'(SEC_LIMIT));
                end
                ACT_DIV:
                begin
                    if (q_fac == '0)
                    begin
                        flag_next.dbz = 1'b1;
                    end
                    else
                    begin
                        r_next   = q_ta;
                        den_next = q_fac;
                    end
                end
                default:
                begin
                    r_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_v_reg <= 1'b0;
        end
        else if (adv)
        begin
            op_v_reg <= q_pop;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_r_reg    <= r_next;
            op_den_reg  <= den_next;
            op_flag_reg <= flag_next;
        end
    end

    // factor divider
    logic               f_v;
    logic [TOT_W-1:0]   f_q;
    logic [FLAG_W-1:0]  f_s;

    dau_div #(.N(TOT_W), .D(FAC_W), .Q(TOT_W), .P(FLAG_W)) u_div_fac (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .in_valid(op_v_reg), .num(op_r_reg), .den(op_den_reg), .side_in(op_flag_reg),
        .out_valid(f_v), .quo(f_q), .rem(), .side_out(f_s)
    );

    // days
    logic                 d_v;
    logic [DAY_BITS-1:0]  d_q;
    logic [DAY_REM_W-1:0] d_r;
    logic [FLAG_W-1:0]    d_s;

    dau_cdiv #(.N(TOT_W), .DIV(SEC_PER_DAY), .SH(DAY_SHIFT), .Q(DAY_BITS),
               .R(DAY_REM_W), .P(FLAG_W)) u_div_day (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .in_valid(f_v), .num(f_q), .side_in(f_s),
        .out_valid(d_v), .quo(d_q), .rem(d_r), .side_out(d_s)
    );

    // hours
    logic                  h_v;
    logic [HOUR_W-1:0]     h_q;
    logic [HOUR_REM_W-1:0] h_r;
    logic [HS_W-1:0]       h_s;

    dau_cdiv #(.N(DAY_REM_W), .DIV(SEC_PER_HOUR), .SH(HOUR_SHIFT), .Q(HOUR_W),
               .R(HOUR_REM_W), .P(HS_W)) u_div_hour (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .in_valid(d_v), .num(d_r), .side_in({d_q, d_s}),
        .out_valid(h_v), .quo(h_q), .rem(h_r), .side_out(h_s)
    );

    // minutes and seconds
    logic              m_v;
    logic [MIN_W-1:0]  m_q;
    logic [SEC_W-1:0]  m_r;
    logic [MS_W-1:0]   m_s;

    dau_cdiv #(.N(HOUR_REM_W), .DIV(SEC_PER_MIN), .SH(MIN_SHIFT), .Q(MIN_W),
               .R(SEC_W), .P(MS_W)) u_div_min (
        .clk(clk), .rst_n(rst_n), .en(adv),
        .in_valid(h_v), .num(h_r), .side_in({h_q, h_s}),
        .out_valid(m_v), .quo(m_q), .rem(m_r), .side_out(m_s)
    );

    // output register
    flag_t               m_flag;
    logic [DAY_BITS-1:0] m_day;
    logic [HOUR_W-1:0]   m_hour;
    logic [31:0]         day32;

    logic                out_valid_reg;
    logic [DAY_W-1:0]    day_reg, day_next;
    logic [HOUR_W-1:0]   hour_reg, hour_next;
    logic [MIN_W-1:0]    min_reg, min_next;
    logic [SEC_W-1:0]    sec_reg, sec_next;
    flag_t               flag_reg;

    always_comb
    begin
        m_flag = flag_t'(m_s[FLAG_W-1:0]);
        m_day  = m_s[HS_W-1:FLAG_W];
        m_hour = m_s[MS_W-1:HS_W];
        day32  = 32'(m_day);
        if (m_flag.ovf)
        begin
            day_next  = DAY_SAT;
            hour_next = HOUR_W'(HOUR_PER_DAY - 1);
            min_next  = MIN_W'(MIN_PER_HOUR - 1);
            sec_next  = SEC_W'(SEC_PER_MIN - 1);
        end
        else
        begin
            day_next  = day32[DAY_W-1:0];
            hour_next = m_hour;
            min_next  = m_q;
            sec_next  = m_r;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= m_v;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            day_reg  <= day_next;
            hour_reg <= hour_next;
            min_reg  <= min_next;
            sec_reg  <= sec_next;
            flag_reg <= m_flag;
        end
    end

    assign out_valid      = out_valid_reg;
    assign res_day        = day_reg;
    assign res_hour       = hour_reg;
    assign res_minute     = min_reg;
    assign res_second     = sec_reg;
    assign negative       = flag_reg.neg;
    assign overflow       = flag_reg.ovf;
    assign divide_by_zero = flag_reg.dbz;
    assign bad_operand    = flag_reg.bad;
    assign a_greater      = flag_reg.gt;
    assign a_less         = flag_reg.lt;
    assign a_equal        = flag_reg.eq;

endmodule
